FILE: rtl/ppe_pkg.sv
`timescale 1ns / 1ps

package ppe_pkg;

    // fixed field widths
    localparam int OP_W        = 3;
    localparam int IDX_W       = 4;
    localparam int COEFF_WIDTH = 16;
    localparam int POINT_WIDTH = 16;
    localparam int VAL_W       = 64;
    localparam int HALF_W      = VAL_W / 2;

    // default store depth
    localparam int NUM_COEFFS_DEF = 10;

    localparam logic signed [VAL_W-1:0] S64_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] S64_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A = 3'd0,
        OP_LOAD_B = 3'd1,
        OP_SUM    = 3'd2,
        OP_DIFF   = 3'd3,
        OP_PROD   = 3'd4,
        OP_DERIV  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        MODE_SUM,
        MODE_DIFF,
        MODE_A,
        MODE_B,
        MODE_DERIV
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_MCHK,
        S_ADD,
        S_OUT
    } state_t;

    typedef struct packed {
        op_t                           op;
        logic [IDX_W-1:0]              coeff_index;
        logic signed [COEFF_WIDTH-1:0] coeff_value;
        logic signed [POINT_WIDTH-1:0] eval_point;
    } in_beat_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    saturated;
    } out_beat_t;

    // multiplier control from the sequencer
    typedef struct packed {
        logic       load;
        logic       step;
        logic [1:0] sel;
        logic       finish;
    } mul_ctrl_t;

    // multiplier status back to the sequencer
    typedef struct packed {
        logic signed [VAL_W-1:0] result;
        logic                    sat;
        logic                    b_hi_zero;
    } mul_stat_t;

endpackage

FILE: rtl/polynomial_pair_evaluator_top.sv
`timescale 1ns / 1ps

// Polynomial pair evaluator: two coefficient stores A and B, evaluated by Horner.
// Command channel: cmd is taken at a rising edge with start high and busy low.
//   Load A / load B write one coefficient (ignored past the store depth)
//   and do not raise busy; they return nothing. Unused op codes are dropped likewise.
//   Evaluate ops (sum, difference, product, derivative of A) raise busy until
//   the result beat is out.
// Result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall, so each beat must be taken in that cycle.
// Sequence: each Horner step runs on the one shared multiplier
//   (operand load, two 32x32 partial products, saturate/resolve, add).
//   Sum/difference step through every coefficient from the top; the derivative
//   stops above the constant term. Product: two passes plus a final 64x64
//   multiply of 2 or 4 partial products.
//   busy drops in the done cycle, so a new command may be taken there.
// Reset: both stores read as zero (per-entry valid bits cleared at once);
//   no clearing pass is needed, the block is ready right after reset.
module polynomial_pair_evaluator_top #(
    parameter int NUM_COEFFS = ppe_pkg::NUM_COEFFS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ppe_pkg::in_beat_t  cmd,
    output logic               done,
    output ppe_pkg::out_beat_t result
);

    import ppe_pkg::*;

    localparam int CIW = $clog2(NUM_COEFFS);
    // widest prepared coefficient: i * a_i or a_i +/- b_i
    localparam int CEW = COEFF_WIDTH + CIW + 1;
    localparam logic [CIW-1:0] TOP_IDX = CIW'(NUM_COEFFS - 1);

    // sequencer
    state_t                  state_reg, state_next;
    mode_t                   mode_reg, mode_next;
    logic                    fin_reg, fin_next;     // final product multiply
    logic [CIW-1:0]          idx_reg, idx_next;
    logic [1:0]              pp_reg, pp_next;

    // datapath
    logic signed [VAL_W-1:0]       acc_reg, acc_next;
    logic signed [VAL_W-1:0]       pa_reg, pa_next;   // A(x) for the product
    logic signed [POINT_WIDTH-1:0] x_reg, x_next;
    logic                          sat_reg, sat_next;
    logic signed [CEW-1:0]         coef_reg, coef_next;
    logic                          prep_reg;

    // stores and valid bits
    logic [NUM_COEFFS-1:0]   vld_a_reg, vld_b_reg;
    logic                    rva_reg, rvb_reg;
    logic [COEFF_WIDTH-1:0]  ra, rb;

    // result beat
    logic                    done_reg, done_next;
    out_beat_t               res_reg, res_next;

    // shared multiplier
    mul_ctrl_t               mul_ctrl;
    mul_stat_t               mul_stat;
    logic signed [VAL_W-1:0] mul_a, mul_b;

    logic                    accept;
    logic                    is_eval;
    logic                    idx_ok;
    logic [CIW-1:0]          waddr;
    logic                    we_a, we_b;
    logic [CIW-1:0]          low_idx;
    logic                    last_step;
    logic                    mul_last;

    logic signed [COEFF_WIDTH-1:0] ca, cb;
    logic signed [CEW-1:0]         ea, eb, ei;
    logic signed [VAL_W:0]         sum_w;
    logic                          add_ovf;
    logic signed [VAL_W-1:0]       add_res;

    // ---------------- command decode ----------------
    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign is_eval = (cmd.op == OP_SUM) || (cmd.op == OP_DIFF) ||
                     (cmd.op == OP_PROD) || (cmd.op == OP_DERIV);
    assign idx_ok  = (32'(cmd.coeff_index) < NUM_COEFFS);
    assign waddr   = CIW'(cmd.coeff_index);
    assign we_a    = accept && (cmd.op == OP_LOAD_A) && idx_ok;
    assign we_b    = accept && (cmd.op == OP_LOAD_B) && idx_ok;

    // ---------------- coefficient stores ----------------
    // Read address follows idx_reg; data lands in the following cycle.
    ppe_ram #(
        .WIDTH (COEFF_WIDTH),
        .DEPTH (NUM_COEFFS)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (cmd.coeff_value),
        .raddr (idx_reg),
        .rdata (ra)
    );

    ppe_ram #(
        .WIDTH (COEFF_WIDTH),
        .DEPTH (NUM_COEFFS)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (cmd.coeff_value),
        .raddr (idx_reg),
        .rdata (rb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= '0;
            vld_b_reg <= '0;
            rva_reg   <= 1'b0;
            rvb_reg   <= 1'b0;
            prep_reg  <= 1'b0;
        end
        else
        begin
            if (we_a)
            begin
                vld_a_reg[waddr] <= 1'b1;
            end
            if (we_b)
            begin
                vld_b_reg[waddr] <= 1'b1;
            end
            rva_reg  <= vld_a_reg[idx_reg];
            rvb_reg  <= vld_b_reg[idx_reg];
            // read data is fresh the cycle after operand load
            prep_reg <= (state_reg == S_LOAD);
        end
    end

    // ---------------- coefficient prep ----------------
    always_comb
    begin
        ca = rva_reg ? $signed(ra) : '0;
        cb = rvb_reg ? $signed(rb) : '0;
        ea = CEW'(ca);
        eb = CEW'(cb);
        ei = CEW'($signed({1'b0, idx_reg}));
        case (mode_reg)
            MODE_SUM:   coef_next = ea + eb;
            MODE_DIFF:  coef_next = ea - eb;
            MODE_A:     coef_next = ea;
            MODE_B:     coef_next = eb;
            MODE_DERIV: coef_next = ea * ei;
            default:    coef_next = ea;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (prep_reg)
        begin
            coef_reg <= coef_next;
        end
    end

    // ---------------- shared multiplier ----------------
    // Horner steps: acc * x. Product op: A(x) * B(x) at the end.
    assign mul_a = fin_reg ? pa_reg : acc_reg;
    assign mul_b = fin_reg ? acc_reg : VAL_W'(x_reg);

    ppe_mul u_mul (
        .clk  (clk),
        .ctrl (mul_ctrl),
        .a    (mul_a),
        .b    (mul_b),
        .stat (mul_stat)
    );

    // ---------------- saturating add ----------------
    always_comb
    begin
        sum_w   = (VAL_W + 1)'(mul_stat.result) + (VAL_W + 1)'(coef_reg);
        add_ovf = (sum_w[VAL_W] != sum_w[VAL_W-1]);
        if (add_ovf)
        begin
            add_res = sum_w[VAL_W] ? S64_MIN : S64_MAX;
        end
        else
        begin
            add_res = sum_w[VAL_W-1:0];
        end
    end

    assign low_idx   = (mode_reg == MODE_DERIV) ? CIW'(1) : '0;
    assign last_step = (idx_reg == low_idx);
    // x fits the low half, so Horner steps need only two partial products
    assign mul_last  = (pp_reg == 2'd3) || ((pp_reg == 2'd1) && mul_stat.b_hi_zero);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_eval)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_last)
                begin
                    state_next = S_MCHK;
                end
            end
            S_MCHK:
            begin
                state_next = fin_reg ? S_OUT : S_ADD;
            end
            S_ADD:
            begin
                if (last_step && (mode_reg != MODE_A) && (mode_reg != MODE_B))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        mode_next = mode_reg;
        fin_next  = fin_reg;
        idx_next  = idx_reg;
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        pa_next   = pa_reg;
        x_next    = x_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        mul_ctrl  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_eval)
                begin
                    idx_next = TOP_IDX;
                    acc_next = '0;
                    sat_next = 1'b0;
                    fin_next = 1'b0;
                    x_next   = cmd.eval_point;
                    case (cmd.op)
                        OP_DIFF:  mode_next = MODE_DIFF;
                        OP_PROD:  mode_next = MODE_A;
                        OP_DERIV: mode_next = MODE_DERIV;
                        default:  mode_next = MODE_SUM;
                    endcase
                end
            end
            S_LOAD:
            begin
                mul_ctrl.load = 1'b1;
                pp_next       = 2'd0;
            end
            S_MUL:
            begin
                mul_ctrl.step = 1'b1;
                mul_ctrl.sel  = pp_reg;
                pp_next       = pp_reg + 2'd1;
            end
            S_MCHK:
            begin
                mul_ctrl.finish = 1'b1;
            end
            S_ADD:
            begin
                acc_next = add_res;
                sat_next = sat_reg | mul_stat.sat | add_ovf;
                if (last_step)
                begin
                    case (mode_reg)
                        MODE_A:
                        begin
                            // A(x) done, start the B pass
                            pa_next   = add_res;
                            mode_next = MODE_B;
                            idx_next  = TOP_IDX;
                            acc_next  = '0;
                        end
                        MODE_B:
                        begin
                            fin_next = 1'b1;
                        end
                        default:
                        begin
                            done_next          = 1'b1;
                            res_next.value     = add_res;
                            res_next.saturated = sat_reg | mul_stat.sat | add_ovf;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg - CIW'(1);
                end
            end
            S_OUT:
            begin
                done_next          = 1'b1;
                res_next.value     = mul_stat.result;
                res_next.saturated = sat_reg | mul_stat.sat;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_SUM;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
            pp_reg    <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            fin_reg   <= fin_next;
            idx_reg   <= idx_next;
            pp_reg    <= pp_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        pa_reg  <= pa_next;
        x_reg   <= x_next;
        sat_reg <= sat_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: rtl/ppe_ram.sv
`timescale 1ns / 1ps

module ppe_ram #(
    parameter int WIDTH = ppe_pkg::COEFF_WIDTH,
    parameter int DEPTH = ppe_pkg::NUM_COEFFS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ppe_mul.sv
`timescale 1ns / 1ps

// Saturating signed 64x64 multiply, one 32x32 partial product per step.
module ppe_mul (
    input  logic                                clk,
    input  ppe_pkg::mul_ctrl_t                  ctrl,
    input  logic signed [ppe_pkg::VAL_W-1:0]    a,
    input  logic signed [ppe_pkg::VAL_W-1:0]    b,
    output ppe_pkg::mul_stat_t                  stat
);

    import ppe_pkg::*;

    localparam int PROD_W = 2 * VAL_W;

    logic [VAL_W-1:0]        ua_reg, ua_next;
    logic [VAL_W-1:0]        ub_reg, ub_next;
    logic                    neg_reg, neg_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [VAL_W-1:0] res_reg, res_next;
    logic                    sat_reg, sat_next;

    logic [HALF_W-1:0]       a_half, b_half;
    logic [VAL_W-1:0]        pp;
    logic [PROD_W-1:0]       pp_shifted;
    logic [VAL_W-1:0]        limit;
    logic                    over;

    always_comb
    begin
        a_half = ctrl.sel[0] ? ua_reg[VAL_W-1:HALF_W] : ua_reg[HALF_W-1:0];
        b_half = ctrl.sel[1] ? ub_reg[VAL_W-1:HALF_W] : ub_reg[HALF_W-1:0];
        pp     = VAL_W'(a_half) * VAL_W'(b_half);
        case (ctrl.sel)
            2'd0:    pp_shifted = PROD_W'(pp);
            2'd3:    pp_shifted = PROD_W'(pp) << VAL_W;
            default: pp_shifted = PROD_W'(pp) << HALF_W;
        endcase

        // magnitude limit: 2^63 for a negative result, 2^63-1 otherwise
        limit = neg_reg ? VAL_W'(S64_MIN) : VAL_W'(S64_MAX);
        over  = (prod_reg[PROD_W-1:VAL_W] != '0) || (prod_reg[VAL_W-1:0] > limit);

        ua_next   = ua_reg;
        ub_next   = ub_reg;
        neg_next  = neg_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        sat_next  = sat_reg;

        if (ctrl.load)
        begin
            ua_next   = a[VAL_W-1] ? VAL_W'(0) - VAL_W'(a) : VAL_W'(a);
            ub_next   = b[VAL_W-1] ? VAL_W'(0) - VAL_W'(b) : VAL_W'(b);
            neg_next  = a[VAL_W-1] ^ b[VAL_W-1];
            prod_next = '0;
        end
        else if (ctrl.step)
        begin
            prod_next = prod_reg + pp_shifted;
        end
        else if (ctrl.finish)
        begin
            sat_next = over;
            if (over)
            begin
                res_next = neg_reg ? S64_MIN : S64_MAX;
            end
            else
            begin
                res_next = neg_reg ? $signed(VAL_W'(0) - prod_reg[VAL_W-1:0])
                                   : $signed(prod_reg[VAL_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        sat_reg  <= sat_next;
    end

    assign stat.result    = res_reg;
    assign stat.sat       = sat_reg;
    assign stat.b_hi_zero = (ub_reg[VAL_W-1:HALF_W] == '0);

endmodule
